[rtl/ihtq_pkg.sv]
package ihtq_pkg;

  localparam int unsigned CapacityDef = 64;
  localparam int unsigned IdSpaceDef  = 1024;

  localparam int unsigned IdW      = 10;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned TimeoutW = 24;
  localparam int unsigned ElapsedW = 16;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned OpW      = 2;

  localparam logic [OpW-1:0] OpArm     = 2'd0;
  localparam logic [OpW-1:0] OpAdjust  = 2'd1;
  localparam logic [OpW-1:0] OpAdvance = 2'd2;
  localparam logic [OpW-1:0] OpClear   = 2'd3;

  localparam logic [StatusW-1:0] StatusOk      = 2'd0;
  localparam logic [StatusW-1:0] StatusFull    = 2'd1;
  localparam logic [StatusW-1:0] StatusUnknown = 2'd2;

  localparam logic [TimeoutW-1:0] DelayMax = '1;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [TimeW-1:0] expiry;
  } heap_entry_t;

  typedef enum logic [3:0] {
    ST_INIT,
    ST_IDLE,
    ST_LOOK,
    ST_FIND,
    ST_DN_RD,
    ST_DN_CMP,
    ST_UP_RD,
    ST_UP_CMP,
    ST_ADV,
    ST_ADV_CHK,
    ST_POP_LD,
    ST_HEAD,
    ST_EMIT
  } state_e;

  // wrap-safe time order
  function automatic logic earlier(input logic [TimeW-1:0] a, input logic [TimeW-1:0] b);
    logic [TimeW-1:0] diff;
    diff = a - b;
    return diff[TimeW-1];
  endfunction

endpackage

[rtl/indexed_heap_timer_queue_core.sv]
// Timer queue: binary min-heap of armed timers ordered by expiry, with an
// id-to-slot table and a millisecond time counter.
// Commands: op_i/timer_id_i/timeout_ms_i/elapsed_ms_i transfer when start_i
// is high and busy_o is low. Arm adds or refreshes a timer, adjust refreshes
// a known one, advance moves time and pops every expired timer, clear
// empties the queue.
// Results: each is shown for one cycle with valid_o high; last_o marks the
// final result of a command. The receiver cannot stall; busy_o stays high
// until the final result has been shown.
// A command runs longer for each heap level that a sift walks (up to
// log2(CAPACITY) levels). Advance gives one result per popped timer,
// each costing a sift down from the root. The heap memory has a single
// write port and registered reads.
// Reset: time and entry count clear at once; then a pass over all
// ID_SPACE entries clears the id table, with busy_o high, before the
// first command transfers.
module indexed_heap_timer_queue_core
  import ihtq_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef,
  parameter int unsigned ID_SPACE = IdSpaceDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  logic [OpW-1:0]      op_i,
  input  logic [IdW-1:0]      timer_id_i,
  input  logic [TimeoutW-1:0] timeout_ms_i,
  input  logic [ElapsedW-1:0] elapsed_ms_i,
  output logic                valid_o,
  output logic [IdW-1:0]      expired_id_o,
  output logic                expired_valid_o,
  output logic [StatusW-1:0]  status_o,
  output logic                next_valid_o,
  output logic [TimeoutW-1:0] next_delay_ms_o,
  output logic                last_o
);

  localparam int unsigned SlotW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned ChW   = SlotW + 2;
  localparam int unsigned IdxW  = (ID_SPACE > 1) ? $clog2(ID_SPACE) : 1;
  localparam int unsigned ExtW  = 17;
  localparam logic [ExtW-1:0] IdLimit  = ExtW'(ID_SPACE);
  localparam logic [CntW-1:0] CapCount = CntW'(CAPACITY);
  localparam logic [IdxW-1:0] ClrLast  = IdxW'(ID_SPACE - 1);

  heap_entry_t heap_mem [CAPACITY];
  logic [SlotW-1:0] slot_mem [ID_SPACE];

  state_e state_q, state_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [OpW-1:0]      op_q, op_d;
  logic [IdW-1:0]      id_q, id_d;
  logic [TimeoutW-1:0] tout_q, tout_d;
  logic [SlotW-1:0]    pos_q, pos_d;
  heap_entry_t         cur_q, cur_d;
  logic                moved_q, moved_d;
  logic                pop_q, pop_d;
  logic                exp_q, exp_d;
  logic [IdW-1:0]      eid_q, eid_d;
  logic [StatusW-1:0]  status_q, status_d;
  logic [IdxW-1:0]     clr_q, clr_d;

  heap_entry_t      rd_a_q, rd_b_q;
  logic [SlotW-1:0] rd_a_addr, rd_b_addr;
  logic [SlotW-1:0] slot_rd_q;

  logic             heap_we;
  logic [SlotW-1:0] heap_waddr;
  heap_entry_t      heap_wdata;
  logic             slot_we;
  logic [IdxW-1:0]  slot_waddr;
  logic [SlotW-1:0] slot_wdata;

  logic             accept;
  logic [ExtW-1:0]  in_id_ext, q_id_ext;
  logic [ChW-1:0]   child, child1, n_ext;
  heap_entry_t      pick;
  logic [SlotW-1:0] pick_addr;
  logic [CntW-1:0]  n_pop;
  logic [TimeW-1:0] head_diff;
  logic             head_due;

  assign accept    = start_i && !busy_o;
  assign in_id_ext = ExtW'(timer_id_i);
  assign q_id_ext  = ExtW'(id_q);
  assign child     = ChW'({pos_q, 1'b1});
  assign child1    = child + ChW'(1);
  assign n_ext     = ChW'(count_q);
  assign n_pop     = count_q - CntW'(1);
  assign head_diff = rd_a_q.expiry - now_q;
  assign head_due  = (count_q != '0) && !earlier(now_q, rd_a_q.expiry);

  always_comb begin
    if ((child1 < n_ext) && earlier(rd_b_q.expiry, rd_a_q.expiry)) begin
      pick      = rd_b_q;
      pick_addr = child1[SlotW-1:0];
    end else begin
      pick      = rd_a_q;
      pick_addr = child[SlotW-1:0];
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[heap_waddr] <= heap_wdata;
    end
    rd_a_q <= heap_mem[rd_a_addr];
    rd_b_q <= heap_mem[rd_b_addr];
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (accept) begin
      slot_rd_q <= slot_mem[in_id_ext[IdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      now_q   <= '0;
      count_q <= '0;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      now_q   <= now_d;
      count_q <= count_d;
      clr_q   <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    id_q     <= id_d;
    tout_q   <= tout_d;
    pos_q    <= pos_d;
    cur_q    <= cur_d;
    moved_q  <= moved_d;
    pop_q    <= pop_d;
    exp_q    <= exp_d;
    eid_q    <= eid_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d    = state_q;
    now_d      = now_q;
    count_d    = count_q;
    clr_d      = clr_q;
    op_d       = op_q;
    id_d       = id_q;
    tout_d     = tout_q;
    pos_d      = pos_q;
    cur_d      = cur_q;
    moved_d    = moved_q;
    pop_d      = pop_q;
    exp_d      = exp_q;
    eid_d      = eid_q;
    status_d   = status_q;
    rd_a_addr  = '0;
    rd_b_addr  = '0;
    heap_we    = 1'b0;
    heap_waddr = pos_q;
    heap_wdata = cur_q;
    slot_we    = 1'b0;
    slot_waddr = IdxW'(ExtW'(cur_q.id));
    slot_wdata = pos_q;

    unique case (state_q)
      ST_INIT: begin
        slot_we    = 1'b1;
        slot_waddr = clr_q;
        slot_wdata = '0;
        clr_d      = clr_q + IdxW'(1);
        if (clr_q == ClrLast) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          op_d     = op_i;
          id_d     = timer_id_i;
          tout_d   = timeout_ms_i;
          exp_d    = 1'b0;
          eid_d    = '0;
          status_d = StatusOk;
          moved_d  = 1'b0;
          pop_d    = 1'b0;
          unique case (op_i)
            OpClear: begin
              count_d = '0;
              state_d = ST_HEAD;
            end
            OpAdvance: begin
              now_d   = now_q + TimeW'(elapsed_ms_i);
              state_d = ST_ADV;
            end
            default: state_d = ST_LOOK;
          endcase
        end
      end
      ST_LOOK: begin
        rd_a_addr = slot_rd_q;
        pos_d     = slot_rd_q;
        state_d   = ST_FIND;
      end
      ST_FIND: begin
        cur_d.id     = id_q;
        cur_d.expiry = now_q + TimeW'(tout_q);
        if ((q_id_ext < IdLimit) && (CntW'(pos_q) < count_q) && (rd_a_q.id == id_q)) begin
          state_d = ST_DN_RD;
        end else if ((op_q == OpAdjust) || (q_id_ext >= IdLimit)) begin
          status_d = StatusUnknown;
          state_d  = ST_HEAD;
        end else if (count_q >= CapCount) begin
          status_d = StatusFull;
          state_d  = ST_HEAD;
        end else begin
          pos_d   = count_q[SlotW-1:0];
          count_d = count_q + CntW'(1);
          state_d = ST_UP_RD;
        end
      end
      ST_DN_RD: begin
        rd_a_addr = child[SlotW-1:0];
        rd_b_addr = child1[SlotW-1:0];
        if (child < n_ext) begin
          state_d = ST_DN_CMP;
        end else if (pop_q || moved_q) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          state_d = ST_HEAD;
        end else begin
          state_d = ST_UP_RD;
        end
      end
      ST_DN_CMP: begin
        if (!earlier(cur_q.expiry, pick.expiry)) begin
          // move the smaller child up into the hole
          heap_we    = 1'b1;
          heap_wdata = pick;
          slot_we    = 1'b1;
          slot_waddr = IdxW'(ExtW'(pick.id));
          pos_d      = pick_addr;
          moved_d    = 1'b1;
          state_d    = ST_DN_RD;
        end else if (pop_q || moved_q) begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          state_d = ST_HEAD;
        end else begin
          state_d = ST_UP_RD;
        end
      end
      ST_UP_RD: begin
        rd_a_addr = SlotW'((pos_q - SlotW'(1)) >> 1);
        if (pos_q != '0) begin
          state_d = ST_UP_CMP;
        end else begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          state_d = ST_HEAD;
        end
      end
      ST_UP_CMP: begin
        if (earlier(cur_q.expiry, rd_a_q.expiry)) begin
          heap_we    = 1'b1;
          heap_wdata = rd_a_q;
          slot_we    = 1'b1;
          slot_waddr = IdxW'(ExtW'(rd_a_q.id));
          pos_d      = SlotW'((pos_q - SlotW'(1)) >> 1);
          state_d    = ST_UP_RD;
        end else begin
          heap_we = 1'b1;
          slot_we = 1'b1;
          state_d = ST_HEAD;
        end
      end
      ST_ADV: begin
        rd_a_addr = '0;
        state_d   = ST_ADV_CHK;
      end
      ST_ADV_CHK: begin
        rd_a_addr = n_pop[SlotW-1:0];
        if (head_due) begin
          exp_d   = 1'b1;
          eid_d   = rd_a_q.id;
          count_d = n_pop;
          pop_d   = 1'b1;
          pos_d   = '0;
          if (n_pop != '0) begin
            state_d = ST_POP_LD;
          end else begin
            state_d = ST_HEAD;
          end
        end else begin
          state_d = ST_HEAD;
        end
      end
      ST_POP_LD: begin
        cur_d   = rd_a_q;
        state_d = ST_DN_RD;
      end
      ST_HEAD: begin
        rd_a_addr = '0;
        state_d   = ST_EMIT;
      end
      ST_EMIT: begin
        if (exp_q && head_due) begin
          state_d = ST_ADV;
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = (state_q == ST_EMIT);
  assign expired_id_o    = exp_q ? eid_q : '0;
  assign expired_valid_o = exp_q;
  assign status_o        = status_q;
  assign next_valid_o    = (count_q != '0);
  assign last_o          = !(exp_q && head_due);

  always_comb begin
    next_delay_ms_o = '0;
    if (count_q != '0) begin
      if (!head_diff[TimeW-1]) begin
        if (head_diff > TimeW'(DelayMax)) begin
          next_delay_ms_o = DelayMax;
        end else begin
          next_delay_ms_o = head_diff[TimeoutW-1:0];
        end
      end
    end
  end

  a_valid_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> busy_o) else $error("result shown while idle");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapCount) else $error("heap count beyond capacity");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o) else $error("command transfer did not start work");

  a_more_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !last_o) |=> (!valid_o && busy_o))
    else $error("non-final result not followed by more work");

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
  import ihtq_pkg::*;

  localparam int Cap     = 64;
  localparam int Ids     = 1024;
  localparam int MaxCyc  = 1000000;
  localparam int NumRand = 30;

  typedef struct {
    logic [OpW-1:0]      op;
    logic [IdW-1:0]      id;
    logic [TimeoutW-1:0] timeout;
    logic [ElapsedW-1:0] elapsed;
  } cmd_t;

  typedef struct {
    logic [IdW-1:0]      id;
    logic                ev;
    logic [StatusW-1:0]  status;
    logic                nv;
    logic [TimeoutW-1:0] delay;
    logic                last;
  } res_t;

  typedef struct {
    cmd_t cmd;
    bit   fixed;
    res_t want;
  } row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [OpW-1:0]      op_i = OpArm;
  logic [IdW-1:0]      timer_id_i = '0;
  logic [TimeoutW-1:0] timeout_ms_i = '0;
  logic [ElapsedW-1:0] elapsed_ms_i = '0;
  logic                valid_o;
  logic [IdW-1:0]      expired_id_o;
  logic                expired_valid_o;
  logic [StatusW-1:0]  status_o;
  logic                next_valid_o;
  logic [TimeoutW-1:0] next_delay_ms_o;
  logic                last_o;

  indexed_heap_timer_queue_core dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow timer queue
  logic [IdW-1:0] q_id   [Cap];
  logic [31:0]    q_exp  [Cap];
  int             slot_tab [Ids];
  bit             armed  [Ids];
  int             q_cnt;
  logic [31:0]    now_t;

  res_t pending_res [$];
  int   errors = 0;
  int   cycles = 0;
  int   burst_left = 0;

  function automatic bit is_before(logic [31:0] a, logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return d[31];
  endfunction

  function automatic void swap_slots(int i, int j);
    logic [IdW-1:0] tid;
    logic [31:0]    tex;
    tid = q_id[i]; tex = q_exp[i];
    q_id[i] = q_id[j]; q_exp[i] = q_exp[j];
    q_id[j] = tid; q_exp[j] = tex;
    slot_tab[q_id[i]] = i;
    slot_tab[q_id[j]] = j;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!is_before(q_exp[i], q_exp[p])) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic bit sift_down(int start, int n);
    int i, c;
    i = start;
    c = 2 * i + 1;
    while (c < n) begin
      if (c + 1 < n && is_before(q_exp[c+1], q_exp[c])) c++;
      if (is_before(q_exp[i], q_exp[c])) break;
      swap_slots(i, c);
      i = c;
      c = 2 * i + 1;
    end
    return i > start;
  endfunction

  function automatic void push_res(logic [IdW-1:0] eid, logic ev, logic [StatusW-1:0] st,
                                   logic last);
    res_t r;
    logic [31:0] d;
    r = '{id: eid, ev: ev, status: st, nv: 1'b0, delay: '0, last: last};
    if (q_cnt > 0) begin
      d = q_exp[0] - now_t;
      r.nv = 1'b1;
      if (!d[31]) r.delay = (d > 32'hFFFFFF) ? DelayMax : d[23:0];
    end
    pending_res.insert(pending_res.size(), r);
  endfunction

  // queue state update plus the results one command produces
  function automatic void predict_cmd(cmd_t c);
    int s, k;
    logic [IdW-1:0] eid;
    case (c.op)
      OpArm, OpAdjust: begin
        if (armed[c.id]) begin
          s = slot_tab[c.id];
          q_exp[s] = now_t + c.timeout;
          if (!sift_down(s, q_cnt)) sift_up(s);
          push_res('0, 1'b0, StatusOk, 1'b1);
        end else if (c.op == OpAdjust) begin
          push_res('0, 1'b0, StatusUnknown, 1'b1);
        end else if (q_cnt >= Cap) begin
          push_res('0, 1'b0, StatusFull, 1'b1);
        end else begin
          s = q_cnt;
          q_id[s] = c.id;
          q_exp[s] = now_t + c.timeout;
          slot_tab[c.id] = s;
          armed[c.id] = 1'b1;
          q_cnt = s + 1;
          sift_up(s);
          push_res('0, 1'b0, StatusOk, 1'b1);
        end
      end
      OpClear: begin
        q_cnt = 0;
        foreach (armed[i]) armed[i] = 1'b0;
        push_res('0, 1'b0, StatusOk, 1'b1);
      end
      default: begin
        now_t = now_t + c.elapsed;
        k = 0;
        while (q_cnt > 0 && k < Cap && !is_before(now_t, q_exp[0])) begin
          eid = q_id[0];
          q_cnt = q_cnt - 1;
          if (q_cnt > 0) begin
            swap_slots(0, q_cnt);
            void'(sift_down(0, q_cnt));
          end
          armed[q_id[q_cnt]] = 1'b0;
          push_res(eid, 1'b1, StatusOk, 1'b0);
          k++;
        end
        if (k == 0) push_res('0, 1'b0, StatusOk, 1'b1);
        else pending_res[pending_res.size()-1].last = 1'b1;
      end
    endcase
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk_i) begin
    res_t w;
    cycles++;
    if (rst_ni && valid_o) begin
      if (pending_res.size() == 0) begin
        report("unexpected result, expired_id", expired_id_o, '0);
      end else begin
        w = pending_res.pop_front();
        if (expired_id_o !== w.id) report("expired_id", expired_id_o, w.id);
        if (expired_valid_o !== w.ev) report("expired_valid", expired_valid_o, w.ev);
        if (status_o !== w.status) report("status", status_o, w.status);
        if (next_valid_o !== w.nv) report("next_valid", next_valid_o, w.nv);
        if (next_delay_ms_o !== w.delay) report("next_delay_ms", next_delay_ms_o, w.delay);
        if (last_o !== w.last) report("last", last_o, w.last);
      end
    end
    if (cycles > MaxCyc) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // fixed rows carry their own expectation, the predictor still tracks state
  task automatic send(cmd_t c, bit fixed, res_t want);
    int n;
    start_i      <= 1'b1;
    op_i         <= c.op;
    timer_id_i   <= c.id;
    timeout_ms_i <= c.timeout;
    elapsed_ms_i <= c.elapsed;
    do @(posedge clk_i); while (busy_o);
    n = pending_res.size();
    predict_cmd(c);
    if (fixed) begin
      while (pending_res.size() > n) pending_res.delete(pending_res.size() - 1);
      pending_res.insert(pending_res.size(), want);
    end
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  function automatic cmd_t mk(logic [OpW-1:0] op, int id, int to, int el);
    cmd_t c;
    c = '{op: op, id: IdW'(id), timeout: TimeoutW'(to), elapsed: ElapsedW'(el)};
    return c;
  endfunction

  function automatic res_t rs(logic ev, logic [StatusW-1:0] st, logic nv,
                              logic [TimeoutW-1:0] dl);
    res_t r;
    r = '{id: '0, ev: ev, status: st, nv: nv, delay: dl, last: 1'b1};
    return r;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int   pick;
    pick = $urandom_range(0, 99);
    c.op = (pick < 40) ? OpArm : (pick < 60) ? OpAdjust : (pick < 97) ? OpAdvance : OpClear;
    c.id = ($urandom_range(0, 3) == 0) ? IdW'($urandom_range(0, Ids - 1))
                                       : IdW'($urandom_range(0, 15));
    case ($urandom_range(0, 9))
      0:       c.timeout = TimeoutW'($urandom());
      1:       c.timeout = DelayMax;
      default: c.timeout = TimeoutW'($urandom_range(0, 3000));
    endcase
    c.elapsed = ($urandom_range(0, 9) == 0) ? ElapsedW'($urandom())
                                            : ElapsedW'($urandom_range(0, 1500));
    return c;
  endfunction

  row_t rows [] = '{
    '{mk(OpAdvance, 0, 0, 0),             1, rs(0, StatusOk, 0, 0)},
    '{mk(OpAdjust, 5, 10, 0),             1, rs(0, StatusUnknown, 0, 0)},
    '{mk(OpClear, 0, 0, 0),               1, rs(0, StatusOk, 0, 0)},
    '{mk(OpArm, 0, 0, 0),                 1, rs(0, StatusOk, 1, 0)},
    '{mk(OpAdvance, 0, 0, 0),             1, '{id: 0, ev: 1, status: StatusOk, nv: 0,
                                               delay: 0, last: 1}},
    '{mk(OpArm, 1023, 24'hFFFFFF, 0),     1, rs(0, StatusOk, 1, DelayMax)},
    '{mk(OpArm, 1, 100, 0),               0, '{default: '0}},
    '{mk(OpArm, 2, 100, 0),               0, '{default: '0}},
    '{mk(OpArm, 3, 50, 0),                0, '{default: '0}},
    '{mk(OpAdjust, 1, 10, 0),             0, '{default: '0}},
    '{mk(OpArm, 2, 200, 0),               0, '{default: '0}},
    '{mk(OpAdvance, 0, 0, 16'hFFFF),      0, '{default: '0}},
    '{mk(OpAdjust, 1023, 0, 0),           0, '{default: '0}},
    '{mk(OpAdvance, 0, 0, 0),             0, '{default: '0}},
    '{mk(OpArm, 682, 24'hAAAAAA, 16'h5555), 0, '{default: '0}},
    '{mk(OpArm, 341, 24'h555555, 16'hAAAA), 0, '{default: '0}},
    '{mk(OpArm, 7, 5, 0),                 0, '{default: '0}},
    '{mk(OpArm, 8, 5, 0),                 0, '{default: '0}},
    '{mk(OpAdvance, 0, 0, 16'hAAAA),      0, '{default: '0}},
    '{mk(OpAdvance, 0, 0, 16'h5555),      0, '{default: '0}},
    '{mk(OpClear, 0, 0, 0),               1, rs(0, StatusOk, 0, 0)},
    '{mk(OpAdvance, 0, 0, 16'hFFFF),      1, rs(0, StatusOk, 0, 0)},
    '{mk(OpAdjust, 7, 0, 0),              1, rs(0, StatusUnknown, 0, 0)}
  };

  initial begin
    res_t none;
    none = '{default: '0};
    q_cnt = 0;
    now_t = '0;
    foreach (armed[i]) armed[i] = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send(rows[i].cmd, rows[i].fixed, rows[i].want);

    for (int n = 0; n < NumRand; n++) begin
      if (n == 10) begin
        // fill the heap, overflow it, refresh while full, then drain in one advance
        send(mk(OpClear, 0, 0, 0), 0, none);
        for (int k = 0; k <= Cap; k++)
          send(mk(OpArm, 100 + k, $urandom_range(0, 4000), 0), 0, none);
        send(mk(OpArm, 100 + $urandom_range(0, Cap - 1), $urandom_range(0, 4000), 0), 0, none);
        send(mk(OpAdvance, 0, 0, 16'hFFFF), 0, none);
      end
      send(rand_cmd(), 0, none);
    end
    start_i <= 1'b0;

    while (pending_res.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/ihtq_pkg.sv
rtl/indexed_heap_timer_queue_core.sv
tb/tb.sv
